// ===== hw/rtl/tccw_pkg.sv =====
// Shared types and constants for the text console cell writer.
package tccw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int COLOR_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [COL_W-1:0] COL_MAX = 7'd127;

  localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;

  // Blank cell: a space in black on black.
  localparam logic [CELL_W-1:0] CELL_BLANK = 16'h0020;

  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'd1;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  typedef struct packed {
    logic                emit;
    logic [ADDR_W-1:0]   addr;
    logic [CELL_W-1:0]   value;
  } cell_req_t;

endpackage

// ===== hw/rtl/tccw_cursor.sv =====
// Cursor state and per-character step: cursor update and cell write request.
module tccw_cursor import tccw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic [CHAR_W-1:0]  char_byte,
  input  logic [COLOR_W-1:0] fg_color,
  input  logic [COLOR_W-1:0] back_color,
  output cell_req_t          req
);

  localparam logic [COL_W-1:0] LINE_W = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0] SCREEN_H = ROW_W'(ROWS);
  localparam int FULL_W = COL_W + ROW_W;

  logic [COL_W-1:0] cursor_column_r, cursor_column_nxt;
  logic [ROW_W-1:0] cursor_row_r, cursor_row_nxt;

  logic [COL_W-1:0] col_pre;
  logic [ROW_W-1:0] row_pre;
  logic [COL_W-1:0] col_addr;
  logic [COL_W:0]   tab_sum;
  logic [COL_W:0]   tab_col;
  logic [FULL_W-1:0] addr_full;
  logic             wr;
  logic [CELL_W-1:0] wr_value;

  always_comb begin
    col_pre  = cursor_column_r;
    row_pre  = cursor_row_r;
    // wrap a column at or past the line width before handling the byte
    if (cursor_column_r >= LINE_W) begin
      col_pre = '0;
      if (cursor_row_r < SCREEN_H) row_pre = cursor_row_r + 1'b1;
    end

    tab_sum  = {1'b0, col_pre} + (COL_W+1)'(4);
    tab_col  = tab_sum & ~(COL_W+1)'(3);

    cursor_column_nxt = col_pre;
    cursor_row_nxt    = row_pre;
    col_addr          = col_pre;
    wr                = 1'b0;
    wr_value          = {back_color, fg_color, char_byte};

    case (char_byte)
      CHAR_NUL: begin
        cursor_column_nxt = cursor_column_r;
        cursor_row_nxt    = cursor_row_r;
      end
      CHAR_NEWLINE: begin
        cursor_column_nxt = '0;
        if (row_pre < SCREEN_H) cursor_row_nxt = row_pre + 1'b1;
      end
      CHAR_RETURN: begin
        cursor_column_nxt = '0;
      end
      CHAR_TAB: begin
        cursor_column_nxt = (tab_col > {1'b0, COL_MAX}) ? COL_MAX : tab_col[COL_W-1:0];
      end
      CHAR_BACKSPACE: begin
        if (col_pre != '0) begin
          cursor_column_nxt = col_pre - 1'b1;
          col_addr          = col_pre - 1'b1;
          wr                = 1'b1;
          wr_value          = CELL_BLANK;
        end
      end
      default: begin
        wr = 1'b1;
        if (col_pre < COL_MAX) cursor_column_nxt = col_pre + 1'b1;
      end
    endcase

    addr_full = FULL_W'(row_pre) * FULL_W'(COLUMNS) + FULL_W'(col_addr);

    // drop writes on the row below the screen
    req.emit  = wr && (row_pre < SCREEN_H);
    req.addr  = addr_full[ADDR_W-1:0];
    req.value = wr_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_column_r <= '0;
      cursor_row_r    <= '0;
    end else if (advance) begin
      cursor_column_r <= cursor_column_nxt;
      cursor_row_r    <= cursor_row_nxt;
    end
  end

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_row_r <= SCREEN_H)
    else $error("cursor row past screen height");

  a_nul_holds: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (char_byte == CHAR_NUL) |=> $stable(cursor_column_r) && $stable(cursor_row_r))
    else $error("zero byte moved the cursor");

  a_emit_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    advance && req.emit |=> cursor_row_r < SCREEN_H)
    else $error("cell write left cursor below screen");

endmodule

// ===== hw/rtl/text_console_cell_writer_unit.sv =====
// Top level of the text console cell writer: input stage, cursor step, result register.
// One character is accepted per cycle while the result port is not stalled; each transfer passes
// an input register, a combinational cursor update and address multiply-add, and a result
// register. Throughput is one character per cycle while out_ready holds, set by the cursor
// register loop. Control bytes other than a backspace that blanks a cell, and writes below the
// last row, give no result. The user is to set colors through the cfg port only while idle;
// the block itself does not enforce this.
module text_console_cell_writer_unit import tccw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAR_W-1:0]    in_char_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDR_W-1:0]    out_cell_address,
  output logic [CELL_W-1:0]    out_cell_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata
);

  logic [COLOR_W-1:0] fg_r, bg_r;
  logic               stage_valid_r;
  logic [CHAR_W-1:0]  stage_char_r;
  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [CELL_W-1:0]  out_value_r;
  logic               advance;
  cell_req_t          req;

  // advance the staged character when the result slot is free or draining
  assign advance  = stage_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stage_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOREGROUND: fg_r <= cfg_wdata;
        REG_BACKGROUND: bg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ready) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) stage_char_r <= in_char_byte;
  end

  tccw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .char_byte  (stage_char_r),
    .fg_color   (fg_r),
    .back_color (bg_r),
    .req        (req)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= req.emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req.emit) begin
      out_addr_r  <= req.addr;
      out_value_r <= req.value;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_address = out_addr_r;
  assign out_cell_value   = out_value_r;

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r && !advance |=> stage_valid_r && $stable(stage_char_r))
    else $error("staged character lost while stalled");

  a_fg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == REG_FOREGROUND) |=> fg_r == $past(cfg_wdata))
    else $error("foreground write not taken");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_addr_r) && $stable(out_value_r))
    else $error("pending cell write changed while stalled");

endmodule
